### design/irpc_pkg.sv
// Shared types and constants for the interrupt register preservation checker.
// No dependencies; every other design file but irpc_ram refers to this package by scope.
`default_nettype none

package irpc_pkg;

  localparam int unsigned SP_W            = 8;
  localparam int unsigned CTX_DEPTH       = 256;
  localparam int unsigned NMI_EXIT_WINDOW = 8;

  // config register indexes
  localparam logic CFG_REG_CHECK  = 1'b0;
  localparam logic CFG_NEST_CHECK = 1'b1;

  typedef enum logic [1:0] {
    CMD_IRQ = 2'd0,
    CMD_NMI = 2'd1,
    CMD_RET = 2'd2,
    CMD_CLR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FAULT_NONE         = 2'd0,
    FAULT_NMI_NESTED   = 2'd1,
    FAULT_REG_MISMATCH = 2'd2
  } fault_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_CHECK = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [SP_W-1:0]   stack_ptr;
    logic [7:0]        acc_value;
    logic [7:0]        xreg_value;
    logic [7:0]        yreg_value;
    logic [15:0]       insn_pc;
  } in_word_t;

  typedef struct packed {
    logic        failure;
    fault_t      fault_kind;
    logic [15:0] entry_pc;
    logic [7:0]  entry_acc;
    logic [7:0]  entry_xreg;
    logic [7:0]  entry_yreg;
  } out_word_t;

  // saved context, one table entry
  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
  } ctx_t;

  localparam int unsigned CTX_W = $bits(ctx_t);

  // controller -> datapath
  typedef struct packed {
    logic take;   // word accepted this cycle
    logic check;  // return compare cycle
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic ret_cmd;
  } stat_t;

endpackage

`default_nettype wire

### design/interrupt_register_preservation_checker.sv
// Top level of the interrupt register preservation checker.
// Depends on irpc_pkg, irpc_ctrl, irpc_dp (and through it irpc_ram).
//
//   channel  ports                        handshake
//   input    start, busy, in_word         taken when start && !busy
//   result   out_strobe, out_word         one cycle strobe, no backpressure
//   config   cfg_we, cfg_index, cfg_data  written when cfg_we
//
// Entry and clear words do not raise busy; the result appears the cycle after.
// A return word raises busy: the context RAM read is registered, busy is
// high for the compare cycle and the result follows it.
// Synchronous active-low reset clears all active bits and NMI state at once.
// The receiver cannot stall; every accepted word yields exactly one result.
`default_nettype none

module interrupt_register_preservation_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire irpc_pkg::in_word_t in_word,
  output logic                    out_strobe,
  output irpc_pkg::out_word_t     out_word,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic               cfg_data
);

  irpc_pkg::ctrl_t ctrl;
  irpc_pkg::stat_t stat;

  irpc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  irpc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_word    (in_word),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

### design/irpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module irpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/irpc_ctrl.sv
// Controller state machine: accepts words and sequences the return compare.
// Depends on irpc_pkg.
`default_nettype none

module irpc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire irpc_pkg::stat_t stat,
  output logic                 busy,
  output irpc_pkg::ctrl_t      ctrl
);

  irpc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= irpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    busy       = 1'b0;
    ctrl.take  = 1'b0;
    ctrl.check = 1'b0;
    unique case (state_r)
      irpc_pkg::ST_IDLE: begin
        ctrl.take = start;
        if (start && stat.ret_cmd) begin
          state_nxt = irpc_pkg::ST_CHECK;
        end
      end
      irpc_pkg::ST_CHECK: begin
        busy       = 1'b1;
        ctrl.check = 1'b1;
        state_nxt  = irpc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/irpc_dp.sv
// Datapath: config registers, context RAM with active bits, NMI tracking,
// result register. Depends on irpc_pkg and irpc_ram.
`default_nettype none

module irpc_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic               cfg_data,
  input  wire irpc_pkg::in_word_t in_word,
  input  wire irpc_pkg::ctrl_t    ctrl,
  output irpc_pkg::stat_t         stat,
  output logic                    out_strobe,
  output irpc_pkg::out_word_t     out_word
);

  logic reg_en_r, nest_en_r;

  logic [irpc_pkg::CTX_DEPTH-1:0] active_r, active_nxt;
  logic                           nmi_open_r, nmi_open_nxt;
  logic [irpc_pkg::SP_W-1:0]      level_r, level_nxt;
  logic                           hit_r, hit_nxt;
  logic                           out_valid_r, out_valid_nxt;
  irpc_pkg::out_word_t            out_word_r, out_word_nxt;
  irpc_pkg::in_word_t             item_r;

  irpc_pkg::ctx_t            wr_ctx, rd_ctx;
  logic                      ram_we;
  logic                      mismatch;
  logic [irpc_pkg::SP_W-1:0] sp_diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_en_r  <= 1'b0;
      nest_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irpc_pkg::CFG_REG_CHECK:  reg_en_r  <= cfg_data;
        irpc_pkg::CFG_NEST_CHECK: nest_en_r <= cfg_data;
      endcase
    end
  end

  assign wr_ctx.pc = in_word.insn_pc;
  assign wr_ctx.a  = in_word.acc_value;
  assign wr_ctx.x  = in_word.xreg_value;
  assign wr_ctx.y  = in_word.yreg_value;

  irpc_ram #(
    .WIDTH (irpc_pkg::CTX_W),
    .DEPTH (irpc_pkg::CTX_DEPTH)
  ) u_ctx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_word.stack_ptr),
    .wdata (wr_ctx),
    .raddr (in_word.stack_ptr),
    .rdata (rd_ctx)
  );

  assign stat.ret_cmd = (in_word.command == irpc_pkg::CMD_RET);
  assign sp_diff      = item_r.stack_ptr - level_r;
  assign mismatch     = hit_r && ((rd_ctx.a != item_r.acc_value) ||
                                  (rd_ctx.x != item_r.xreg_value) ||
                                  (rd_ctx.y != item_r.yreg_value));

  always_comb begin
    active_nxt    = active_r;
    nmi_open_nxt  = nmi_open_r;
    level_nxt     = level_r;
    hit_nxt       = hit_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = '0;
    ram_we        = 1'b0;

    if (ctrl.take) begin
      unique case (in_word.command)
        irpc_pkg::CMD_CLR: begin
          active_nxt    = '0;
          nmi_open_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
        end
        irpc_pkg::CMD_IRQ, irpc_pkg::CMD_NMI: begin
          if (reg_en_r) begin
            ram_we                        = 1'b1;
            active_nxt[in_word.stack_ptr] = 1'b1;
          end
          if ((in_word.command == irpc_pkg::CMD_NMI) && nest_en_r) begin
            if (nmi_open_r) begin
              out_word_nxt.failure    = 1'b1;
              out_word_nxt.fault_kind = irpc_pkg::FAULT_NMI_NESTED;
            end else begin
              level_nxt    = in_word.stack_ptr;
              nmi_open_nxt = 1'b1;
            end
          end
          out_valid_nxt = 1'b1;
        end
        irpc_pkg::CMD_RET: begin
          hit_nxt = reg_en_r && active_r[in_word.stack_ptr];
          if (hit_nxt) begin
            active_nxt[in_word.stack_ptr] = 1'b0;
          end
        end
      endcase
    end

    if (ctrl.check) begin
      out_valid_nxt = 1'b1;
      if (mismatch) begin
        out_word_nxt.failure    = 1'b1;
        out_word_nxt.fault_kind = irpc_pkg::FAULT_REG_MISMATCH;
        out_word_nxt.entry_pc   = rd_ctx.pc;
        out_word_nxt.entry_acc  = rd_ctx.a;
        out_word_nxt.entry_xreg = rd_ctx.x;
        out_word_nxt.entry_yreg = rd_ctx.y;
      end else if (nest_en_r && nmi_open_r &&
                   (sp_diff < irpc_pkg::SP_W'(irpc_pkg::NMI_EXIT_WINDOW))) begin
        nmi_open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      nmi_open_r  <= 1'b0;
      level_r     <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      nmi_open_r  <= nmi_open_nxt;
      level_r     <= level_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (ctrl.take) begin
      item_r <= in_word;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_word   = out_word_r;

endmodule

`default_nettype wire

### tb/interrupt_register_preservation_checker_test.sv
// Self-checking testbench for the interrupt register preservation checker.
// Uses irpc_pkg and the interrupt_register_preservation_checker top level; an internal
// predictor models the context table and the NMI state to check every result word.
`default_nettype none

module interrupt_register_preservation_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import irpc_pkg::*;

  localparam int   IDLE_LIMIT    = 2000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      start     = 1'b0;
  in_word_t  ev_word   = '0;
  logic      cfg_we    = 1'b0;
  logic      cfg_index = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      busy;
  logic      out_strobe;
  out_word_t out_word;

  interrupt_register_preservation_checker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (ev_word),
    .out_strobe(out_strobe),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  ctx_t       saved_ctx  [CTX_DEPTH] = '{default: '0};
  logic       saved_live [CTX_DEPTH] = '{default: 1'b0};
  logic       nmi_open     = 1'b0;
  logic [7:0] nmi_level    = '0;
  logic       reg_check_on = 1'b0;
  logic       nmi_check_on = 1'b0;

  in_word_t  queued_events [$];
  out_word_t due_verdicts  [$];
  int        fail_count = 0;
  int        gap_left   = 0;
  logic      steady     = 1'b0;
  int        idle_cycles = 0;

  // stimulus generator state: open handler frames
  in_word_t   frame_stack [$];
  logic [7:0] gen_sp = 8'hFF;

  function automatic out_word_t judge_event(in_word_t w);
    out_word_t  r;
    logic [7:0] lag;
    r = '0;
    case (w.command)
      CMD_CLR: begin
        saved_ctx  = '{default: '0};
        saved_live = '{default: 1'b0};
        nmi_open   = 1'b0;
      end
      CMD_IRQ, CMD_NMI: begin
        if (reg_check_on) begin
          saved_ctx[w.stack_ptr]  = '{pc: w.insn_pc, a: w.acc_value,
                                      x: w.xreg_value, y: w.yreg_value};
          saved_live[w.stack_ptr] = 1'b1;
        end
        if (w.command == CMD_NMI && nmi_check_on) begin
          if (nmi_open) begin
            r.fault_kind = FAULT_NMI_NESTED;
          end else begin
            nmi_level = w.stack_ptr;
            nmi_open  = 1'b1;
          end
        end
      end
      default: begin
        if (reg_check_on && saved_live[w.stack_ptr]) begin
          saved_live[w.stack_ptr] = 1'b0;
          if (saved_ctx[w.stack_ptr].a != w.acc_value ||
              saved_ctx[w.stack_ptr].x != w.xreg_value ||
              saved_ctx[w.stack_ptr].y != w.yreg_value) begin
            r.fault_kind = FAULT_REG_MISMATCH;
            r.entry_pc   = saved_ctx[w.stack_ptr].pc;
            r.entry_acc  = saved_ctx[w.stack_ptr].a;
            r.entry_xreg = saved_ctx[w.stack_ptr].x;
            r.entry_yreg = saved_ctx[w.stack_ptr].y;
          end
        end
        lag = w.stack_ptr - nmi_level;
        if (r.fault_kind == FAULT_NONE && nmi_check_on && nmi_open &&
            lag < NMI_EXIT_WINDOW) begin
          nmi_open = 1'b0;
        end
      end
    endcase
    r.failure = (r.fault_kind != FAULT_NONE);
    return r;
  endfunction

  function automatic in_word_t event_word(cmd_t c, logic [7:0] sp, logic [7:0] a,
                                          logic [7:0] x, logic [7:0] y,
                                          logic [15:0] pc);
    in_word_t w;
    w = '{command: c, stack_ptr: sp, acc_value: a, xreg_value: x,
          yreg_value: y, insn_pc: pc};
    return w;
  endfunction

  // mostly matched entry/return pairs on a moving stack, some noise
  function automatic in_word_t next_random_event();
    in_word_t    w;
    int unsigned pick;
    w = event_word(cmd_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 16'($urandom));
    pick = $urandom_range(0, 99);
    if (frame_stack.size() > 6) pick = 50;
    if (pick < 40) begin
      w.command   = ($urandom_range(0, 2) == 0) ? CMD_NMI : CMD_IRQ;
      w.stack_ptr = gen_sp;
      frame_stack.push_back(w);
      gen_sp = gen_sp - 8'd3 - 8'($urandom_range(0, 3));
    end else if (pick < 80 && frame_stack.size() > 0) begin
      w         = frame_stack.pop_back();
      gen_sp    = w.stack_ptr;
      w.command = CMD_RET;
      w.insn_pc = 16'($urandom);
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0:       w.acc_value  ^= 8'(1 << $urandom_range(0, 7));
          1:       w.xreg_value ^= 8'(1 << $urandom_range(0, 7));
          default: w.yreg_value ^= 8'(1 << $urandom_range(0, 7));
        endcase
      end
    end else if (pick < 84) begin
      w.command = CMD_CLR;
      frame_stack.delete();
    end
    return w;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 40));
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) due_verdicts.push_back(judge_event(ev_word));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (queued_events.size() > 0) begin
          ev_word  <= queued_events.pop_front();
          start    <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_strobe) begin
      if (due_verdicts.size() == 0) begin
        $error("unexpected result word %h", out_word);
        fail_count++;
      end else begin
        exp_w = due_verdicts.pop_front();
        if (out_word.failure !== exp_w.failure) begin
          $error("failure: expected %0d, got %0d", exp_w.failure, out_word.failure);
          fail_count++;
        end
        if (out_word.fault_kind !== exp_w.fault_kind) begin
          $error("fault_kind: expected %0d, got %0d", exp_w.fault_kind,
                 out_word.fault_kind);
          fail_count++;
        end
        if (out_word.entry_pc !== exp_w.entry_pc) begin
          $error("entry_pc: expected %h, got %h", exp_w.entry_pc, out_word.entry_pc);
          fail_count++;
        end
        if (out_word.entry_acc !== exp_w.entry_acc) begin
          $error("entry_acc: expected %h, got %h", exp_w.entry_acc, out_word.entry_acc);
          fail_count++;
        end
        if (out_word.entry_xreg !== exp_w.entry_xreg) begin
          $error("entry_xreg: expected %h, got %h", exp_w.entry_xreg,
                 out_word.entry_xreg);
          fail_count++;
        end
        if (out_word.entry_yreg !== exp_w.entry_yreg) begin
          $error("entry_yreg: expected %h, got %h", exp_w.entry_yreg,
                 out_word.entry_yreg);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_cfg(logic idx, logic val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_REG_CHECK) reg_check_on = val;
    else nmi_check_on = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (queued_events.size() != 0 || start || due_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic reg_en;
    logic nmi_en;
    int   n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // both checks off after reset
    queued_events.push_back(event_word(CMD_IRQ, 8'hFF, 8'h11, 8'h22, 8'h33, 16'h1234));
    queued_events.push_back(event_word(CMD_RET, 8'hFF, 8'h00, 8'h00, 8'h00, 16'h0000));
    queued_events.push_back(event_word(CMD_NMI, 8'h40, 8'h00, 8'h00, 8'h00, 16'h0000));
    queued_events.push_back(event_word(CMD_NMI, 8'h30, 8'h00, 8'h00, 8'h00, 16'h0000));
    queued_events.push_back(event_word(CMD_RET, 8'h40, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    queued_events.push_back(event_word(CMD_CLR, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    drain();

    write_cfg(CFG_REG_CHECK, 1'b1);
    write_cfg(CFG_NEST_CHECK, 1'b1);
    queued_events.push_back(event_word(CMD_CLR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    queued_events.push_back(event_word(CMD_IRQ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    queued_events.push_back(event_word(CMD_RET, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000));
    queued_events.push_back(event_word(CMD_NMI, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    // nested NMI, then mismatched return keeps the NMI open
    queued_events.push_back(event_word(CMD_NMI, 8'hF8, 8'h12, 8'h34, 8'h56, 16'hBEEF));
    queued_events.push_back(event_word(CMD_RET, 8'hF8, 8'h13, 8'h34, 8'h56, 16'h0001));
    queued_events.push_back(event_word(CMD_RET, 8'hF8, 8'h13, 8'h34, 8'h56, 16'h0002));
    queued_events.push_back(event_word(CMD_NMI, 8'h10, 8'h01, 8'h02, 8'h03, 16'h8000));
    // return to inactive entry at the window edge closes the NMI
    queued_events.push_back(event_word(CMD_RET, 8'h07, 8'h00, 8'h00, 8'h00, 16'h0000));
    queued_events.push_back(event_word(CMD_NMI, 8'hFC, 8'hA5, 8'h5A, 8'hC3, 16'h4321));
    queued_events.push_back(event_word(CMD_RET, 8'h03, 8'h00, 8'h00, 8'h00, 16'h0000));
    queued_events.push_back(event_word(CMD_NMI, 8'hFC, 8'hA5, 8'h5A, 8'hC3, 16'h4321));
    queued_events.push_back(event_word(CMD_RET, 8'h04, 8'h00, 8'h00, 8'h00, 16'h0000));
    queued_events.push_back(event_word(CMD_RET, 8'hFC, 8'hA5, 8'h5B, 8'hC3, 16'h0000));
    queued_events.push_back(event_word(CMD_RET, 8'hFB, 8'h00, 8'h00, 8'h00, 16'h0000));
    queued_events.push_back(event_word(CMD_CLR, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    queued_events.push_back(event_word(CMD_NMI, 8'h20, 8'h00, 8'h00, 8'h00, 16'h0000));
    queued_events.push_back(event_word(CMD_IRQ, 8'h30, 8'h00, 8'h00, 8'hAA, 16'h5555));
    queued_events.push_back(event_word(CMD_RET, 8'h30, 8'h00, 8'h00, 8'h55, 16'hAAAA));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase < 4) begin
        reg_en = phase[0];
        nmi_en = phase[1];
      end else begin
        reg_en = 1'($urandom_range(0, 1));
        nmi_en = 1'($urandom_range(0, 1));
      end
      write_cfg(CFG_REG_CHECK, reg_en);
      write_cfg(CFG_NEST_CHECK, nmi_en);
      steady = (phase % 3 == 1);
      if ($urandom_range(0, 3) != 0) begin
        queued_events.push_back(event_word(CMD_CLR, 8'($urandom), 8'($urandom),
                                           8'($urandom), 8'($urandom),
                                           16'($urandom)));
        frame_stack.delete();
      end
      n = $urandom_range(140, 160);
      for (int k = 0; k < n; k++) queued_events.push_back(next_random_event());
      drain();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
